/* src/tlbp_pkg.sv */
package tlbp_pkg;

    // Fixed field widths
    localparam int unsigned POS_W  = 48;
    localparam int unsigned BPM_W  = 26;
    localparam int unsigned SR_W   = 18;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned POS_FRAC_BITS = 16;

    // Input action codes
    localparam logic [1:0] ACT_UPDATE = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Kind of work queued for the back end
    typedef enum logic [1:0] {
        KIND_UPDATE,
        KIND_TICK,
        KIND_CLEAR
    } kind_t;

    // One queued word
    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   pos;
        logic [BPM_W-1:0]   bpm;
        logic               playing;
    } entry_t;

    // Back-end sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

endpackage

/* src/tlbp_front.sv */
module tlbp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  action,
    input  logic [tlbp_pkg::POS_W-1:0]  beat_position,
    input  logic [tlbp_pkg::BPM_W-1:0]  tempo_bpm,
    input  logic                        transport_playing,
    input  logic                        values_valid,
    input  logic                        pop,
    output logic                        head_valid,
    output tlbp_pkg::entry_t            head
);

    tlbp_pkg::entry_t entry_reg [2];
    tlbp_pkg::entry_t new_entry;
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             keep;
    logic             push;

    // Classify the incoming word; invalid updates and unused codes are dropped here
    always_comb
    begin
        new_entry.pos     = beat_position;
        new_entry.bpm     = tempo_bpm;
        new_entry.playing = transport_playing;
        new_entry.kind    = tlbp_pkg::KIND_TICK;
        keep              = 1'b0;
        case (action)
            tlbp_pkg::ACT_UPDATE:
            begin
                new_entry.kind = tlbp_pkg::KIND_UPDATE;
                keep           = values_valid;
            end
            tlbp_pkg::ACT_TICK:
            begin
                new_entry.kind = tlbp_pkg::KIND_TICK;
                keep           = 1'b1;
            end
            tlbp_pkg::ACT_CLEAR:
            begin
                new_entry.kind = tlbp_pkg::KIND_CLEAR;
                keep           = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall && keep;
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    // Two-entry queue pointers
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

/* src/tlbp_div.sv */
module tlbp_div #(
    parameter int unsigned NUM_W = 34
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NUM_W-1:0]            num,
    input  logic [tlbp_pkg::CNT_W-1:0]  den,
    output logic                        done,
    output logic [NUM_W-1:0]            quo
);

    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               cnt_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [tlbp_pkg::CNT_W-1:0]  rem_reg;
    logic [tlbp_pkg::CNT_W-1:0]  rem_next;
    logic [tlbp_pkg::CNT_W-1:0]  den_reg;
    logic [tlbp_pkg::CNT_W-1:0]  den_next;
    logic [NUM_W-1:0]            quo_reg;
    logic [NUM_W-1:0]            quo_next;
    logic [tlbp_pkg::CNT_W:0]    trial;
    logic                        fits;

    // Restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? tlbp_pkg::CNT_W'(trial - {1'b0, den_reg})
                            : trial[tlbp_pkg::CNT_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* src/tlbp_back.sv */
module tlbp_back #(
    parameter int unsigned PHASE_FRACTION_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  tlbp_pkg::entry_t                    head,
    output logic                                pop,
    input  logic [tlbp_pkg::SR_W-1:0]           sample_rate,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [PHASE_FRACTION_BITS+1:0] beat_phase,
    output logic [tlbp_pkg::CNT_W-1:0]          samples_since_start,
    output logic                                div_start,
    output logic [PHASE_FRACTION_BITS+9:0]      div_num,
    output logic [tlbp_pkg::CNT_W-1:0]          div_den,
    input  logic                                div_done,
    input  logic [PHASE_FRACTION_BITS+9:0]      div_quo
);

    localparam int unsigned F  = PHASE_FRACTION_BITS;
    localparam int unsigned FW = F + 2;
    localparam int unsigned NW = F + 10;
    localparam int unsigned CW = tlbp_pkg::CNT_W;
    localparam int unsigned SH = F - tlbp_pkg::POS_FRAC_BITS;

    localparam logic signed [FW-1:0] PH_ONE     = {2'b01, {F{1'b0}}};
    localparam logic signed [FW-1:0] PH_NEG_ONE = {2'b11, {F{1'b0}}};
    localparam logic [F:0]           STEP_ONE   = {1'b1, {F{1'b0}}};
    localparam logic [CW-1:0]        CNT_MAX    = '1;

    tlbp_pkg::state_t              state_reg;
    tlbp_pkg::state_t              state_next;
    logic [tlbp_pkg::POS_W-1:0]    last_pos_reg;
    logic [tlbp_pkg::POS_W-1:0]    last_pos_next;
    logic signed [FW-1:0]          last_frac_reg;
    logic signed [FW-1:0]          last_frac_next;
    logic                          was_playing_reg;
    logic                          was_playing_next;
    logic signed [FW-1:0]          phase_reg;
    logic signed [FW-1:0]          phase_next;
    logic [F:0]                    step_reg;
    logic [F:0]                    step_next;
    logic [CW-1:0]                 since_upd_reg;
    logic [CW-1:0]                 since_upd_next;
    logic [CW-1:0]                 start_cnt_reg;
    logic [CW-1:0]                 start_cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [FW-1:0]          out_phase_reg;
    logic signed [FW-1:0]          out_phase_next;
    logic [CW-1:0]                 out_cnt_reg;
    logic [CW-1:0]                 out_cnt_next;

    logic signed [tlbp_pkg::POS_W-1:0] pos;
    logic                          pos_pos;
    logic                          pos_low;
    logic [FW-1:0]                 frac_hi;
    logic signed [FW-1:0]          frac_lo;
    logic signed [FW-1:0]          frac;
    logic                          active;
    logic                          just_started;
    logic signed [FW:0]            d_raw;
    logic signed [FW:0]            d_adj;
    logic                          d_gt0;
    logic [23:0]                   den60;
    logic signed [FW:0]            tick_sum;
    logic signed [FW:0]            tick_wrap;
    logic                          out_free;

    // Fractional beat phase of the queued position
    assign pos      = $signed(head.pos);
    assign pos_pos  = !pos[tlbp_pkg::POS_W-1] && (pos != '0);
    assign pos_low  = (pos < -48'sd65536);
    assign frac_hi  = FW'(head.pos[15:0]) << SH;
    assign frac_lo  = FW'($signed(head.pos[16:0])) <<< SH;
    assign active   = (head.pos != last_pos_reg) && head.playing;
    assign just_started = head.playing && !was_playing_reg;

    always_comb
    begin
        if (!active)
        begin
            frac = '0;
        end
        else if (pos_pos)
        begin
            frac = $signed(frac_hi);
        end
        else if (pos_low)
        begin
            frac = PH_NEG_ONE;
        end
        else
        begin
            frac = frac_lo;
        end
    end

    // Wrapped phase change since the last update
    assign d_raw = {frac[FW-1], frac} - {last_frac_reg[FW-1], last_frac_reg};
    assign d_adj = d_raw[FW] ? (d_raw + {1'b0, PH_ONE}) : d_raw;
    assign d_gt0 = !d_adj[FW] && (d_adj != '0);

    // 60 * sample_rate as shift and subtract
    assign den60 = ({6'b0, sample_rate} << 6) - ({6'b0, sample_rate} << 2);

    // Phase advance on a tick, wrapping above one
    assign tick_sum  = {phase_reg[FW-1], phase_reg} + $signed({2'b00, step_reg});
    assign tick_wrap = (tick_sum > $signed({1'b0, PH_ONE})) ? (tick_sum - {1'b0, PH_ONE})
                                                           : tick_sum;

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: next state and all state updates
    always_comb
    begin
        state_next       = state_reg;
        last_pos_next    = last_pos_reg;
        last_frac_next   = last_frac_reg;
        was_playing_next = was_playing_reg;
        phase_next       = phase_reg;
        step_next        = step_reg;
        since_upd_next   = since_upd_reg;
        start_cnt_next   = start_cnt_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_phase_next   = out_phase_reg;
        out_cnt_next     = out_cnt_reg;
        pop              = 1'b0;
        div_start        = 1'b0;
        div_num          = '0;
        div_den          = '0;
        case (state_reg)
            tlbp_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.kind)
                        tlbp_pkg::KIND_TICK:
                        begin
                            if (out_free)
                            begin
                                pop            = 1'b1;
                                out_valid_next = 1'b1;
                                out_phase_next = phase_reg;
                                out_cnt_next   = start_cnt_reg;
                                phase_next     = FW'(tick_wrap);
                                since_upd_next = (since_upd_reg == CNT_MAX) ? CNT_MAX
                                                                            : since_upd_reg + 1'b1;
                                start_cnt_next = (start_cnt_reg == CNT_MAX) ? CNT_MAX
                                                                            : start_cnt_reg + 1'b1;
                            end
                        end
                        tlbp_pkg::KIND_CLEAR:
                        begin
                            pop              = 1'b1;
                            step_next        = '0;
                            was_playing_next = 1'b0;
                        end
                        tlbp_pkg::KIND_UPDATE:
                        begin
                            pop              = 1'b1;
                            last_pos_next    = head.pos;
                            last_frac_next   = frac;
                            was_playing_next = head.playing;
                            since_upd_next   = '0;
                            if (!active)
                            begin
                                phase_next = PH_NEG_ONE;
                                step_next  = '0;
                            end
                            else if (just_started)
                            begin
                                phase_next     = '0;
                                start_cnt_next = '0;
                                if (sample_rate == '0)
                                begin
                                    step_next = STEP_ONE;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    div_num    = NW'(head.bpm) << SH;
                                    div_den    = CW'(den60);
                                    state_next = tlbp_pkg::ST_DIV;
                                end
                            end
                            else
                            begin
                                phase_next = frac;
                                if (!d_gt0)
                                begin
                                    step_next = '0;
                                end
                                else if (since_upd_reg == '0)
                                begin
                                    step_next = STEP_ONE;
                                end
                                else
                                begin
                                    // change can reach almost two, keep both integer bits
                                    div_start  = 1'b1;
                                    div_num    = NW'(d_adj[FW-1:0]);
                                    div_den    = since_upd_reg;
                                    state_next = tlbp_pkg::ST_DIV;
                                end
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            tlbp_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    step_next  = (div_quo > NW'(STEP_ONE)) ? STEP_ONE : div_quo[F:0];
                    state_next = tlbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tlbp_pkg::ST_IDLE;
            last_pos_reg    <= '0;
            last_frac_reg   <= '0;
            was_playing_reg <= 1'b0;
            phase_reg       <= '0;
            step_reg        <= '0;
            since_upd_reg   <= '0;
            start_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_pos_reg    <= last_pos_next;
            last_frac_reg   <= last_frac_next;
            was_playing_reg <= was_playing_next;
            phase_reg       <= phase_next;
            step_reg        <= step_next;
            since_upd_reg   <= since_upd_next;
            start_cnt_reg   <= start_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        out_phase_reg <= out_phase_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign out_valid           = out_valid_reg;
    assign beat_phase          = out_phase_reg;
    assign samples_since_start = out_cnt_reg;

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_ONE)
        else $error("phase step above one");
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg <= PH_ONE) && (phase_reg >= PH_NEG_ONE))
        else $error("phase out of range");
    a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlbp_pkg::ST_DIV) |-> !pop)
        else $error("queue popped while dividing");
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == tlbp_pkg::ST_DIV))
        else $error("divider result outside divide state");
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == tlbp_pkg::ST_DIV))
        else $error("divide started without entering divide state");
`endif

endmodule

/* src/tempo_locked_beat_phasor_core.sv */
// Tempo-locked beat phasor. Transport updates (action 0) re-lock a quarter-note phase
// with PHASE_FRACTION_BITS fraction bits; sample ticks (action 1) return one word holding
// the current phase (-1.0 while the transport is inactive) and the samples counted since
// playback started, then advance the phase; clear (action 2) drops the increment and the
// playing flag. Updates flagged invalid and action 3 are dropped without effect. Input
// words enter a two-entry queue and are executed in order. An update that derives a new
// increment runs a serial restoring divider of PHASE_FRACTION_BITS+10 quotient bits (34
// at the default), one quotient bit per cycle, and the queue is not popped meanwhile.
// sample_rate is written through its own port, which is always ready; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module tempo_locked_beat_phasor_core #(
    parameter int unsigned PHASE_FRACTION_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            action,
    input  logic signed [tlbp_pkg::POS_W-1:0]     beat_position,
    input  logic [tlbp_pkg::BPM_W-1:0]            tempo_bpm,
    input  logic                                  transport_playing,
    input  logic                                  values_valid,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [PHASE_FRACTION_BITS+1:0] beat_phase,
    output logic [tlbp_pkg::CNT_W-1:0]            samples_since_start,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tlbp_pkg::SR_W-1:0]             sample_rate
);

    localparam int unsigned NW = PHASE_FRACTION_BITS + 10;

    logic [tlbp_pkg::SR_W-1:0]   sample_rate_reg;
    logic                        head_valid;
    tlbp_pkg::entry_t            head;
    logic                        pop;
    logic                        div_start;
    logic [NW-1:0]               div_num;
    logic [tlbp_pkg::CNT_W-1:0]  div_den;
    logic                        div_done;
    logic [NW-1:0]               div_quo;

    // Sample rate register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= tlbp_pkg::SR_W'(48000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            sample_rate_reg <= sample_rate;
        end
    end

    tlbp_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .beat_position     (beat_position),
        .tempo_bpm         (tempo_bpm),
        .transport_playing (transport_playing),
        .values_valid      (values_valid),
        .pop               (pop),
        .head_valid        (head_valid),
        .head              (head)
    );

    tlbp_div #(
        .NUM_W (NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    tlbp_back #(
        .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head_valid          (head_valid),
        .head                (head),
        .pop                 (pop),
        .sample_rate         (sample_rate_reg),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .beat_phase          (beat_phase),
        .samples_since_start (samples_since_start),
        .div_start           (div_start),
        .div_num             (div_num),
        .div_den             (div_den),
        .div_done            (div_done),
        .div_quo             (div_quo)
    );

endmodule

/* tb/tempo_locked_beat_phasor_core_test.sv */
module tempo_locked_beat_phasor_core_test;

    localparam int FRAC_BITS = 24;
    localparam longint PHASE_ONE = longint'(1) << FRAC_BITS;
    localparam logic signed [FRAC_BITS+1:0] PHASE_INACTIVE = 26'sh3000000;
    localparam logic [tlbp_pkg::BPM_W-1:0] BPM_120 = 26'h0780000;
    localparam logic [tlbp_pkg::BPM_W-1:0] BPM_TOP = 26'h3FFFFFF;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int GAP_MAX = 6;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int DRAIN_CYCLES = 120;
    localparam int FINAL_WAIT_LIMIT = 5000;
    localparam longint RUN_LIMIT = 12000000;

    // One result word
    typedef struct packed {
        logic signed [FRAC_BITS+1:0]     phase;
        logic [tlbp_pkg::CNT_W-1:0]      count;
    } tick_word_t;

    // One row of the directed script
    typedef struct packed {
        logic [1:0]                      act;
        logic signed [tlbp_pkg::POS_W-1:0] pos;
        logic [tlbp_pkg::BPM_W-1:0]      bpm;
        logic                            play;
        logic                            vld;
        logic                            typed;
        logic signed [FRAC_BITS+1:0]     phase;
        logic [tlbp_pkg::CNT_W-1:0]      count;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = tlbp_pkg::ACT_UPDATE;
    logic signed [tlbp_pkg::POS_W-1:0] beat_position = '0;
    logic [tlbp_pkg::BPM_W-1:0] tempo_bpm = '0;
    logic transport_playing = 1'b0;
    logic values_valid = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [FRAC_BITS+1:0] beat_phase;
    logic [tlbp_pkg::CNT_W-1:0] samples_since_start;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [tlbp_pkg::SR_W-1:0] sample_rate = 18'd48000;

    // Phasor state as the block should hold it
    logic [tlbp_pkg::SR_W-1:0]         rate_hz = 18'd48000;
    logic signed [tlbp_pkg::POS_W-1:0] last_pos_q = '0;
    logic signed [FRAC_BITS+1:0]       last_frac_q = '0;
    logic                              was_playing_q = 1'b0;
    logic signed [FRAC_BITS+1:0]       phase_q = '0;
    logic [FRAC_BITS:0]                step_q = '0;
    logic [tlbp_pkg::CNT_W-1:0]        since_update_q = '0;
    logic [tlbp_pkg::CNT_W-1:0]        since_start_q = '0;

    tick_word_t pending_ticks [$];
    int mismatch_count = 0;
    int stall_left = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    logic signed [tlbp_pkg::POS_W-1:0] host_pos = '0;
    logic [tlbp_pkg::BPM_W-1:0] session_bpm = BPM_120;

    logic [tlbp_pkg::SR_W-1:0] rate_plan [7] = '{18'd0, 18'd1, 18'h3FFFF, 18'd8000, 18'd192000,
                                                 18'd44100, 18'd48000};

    // Directed rows; typed expectations only where the value is obvious
    script_row_t script [27] = '{
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b1, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_UPDATE, 48'sh10000, BPM_120, 1'b1, 1'b0, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b1, 26'sh0, 32'd1},
        '{tlbp_pkg::ACT_UPDATE, 48'sh18000, BPM_120, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b1, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_UPDATE, 48'sh18100, BPM_120, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_UPDATE, 48'sh18200, BPM_120, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_UPDATE, 48'shFFFF_FFFD_0000, BPM_120, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b1, PHASE_INACTIVE, 32'd3},
        '{tlbp_pkg::ACT_UPDATE, 48'sh4FF00, BPM_120, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_UPDATE, 48'shFFFF_FFFF_8000, BPM_120, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_UPDATE, 48'sh0, BPM_120, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_UPDATE, 48'sh0, BPM_120, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b1, PHASE_INACTIVE, 32'd6},
        '{tlbp_pkg::ACT_UPDATE, 48'sh8000_0000_0000, BPM_TOP, 1'b0, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{ACT_SPARE,            48'sh7FFF_FFFF_FFFF, BPM_TOP, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_UPDATE, 48'sh7FFF_FFFF_FFFF, BPM_TOP, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b1, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_CLEAR,  48'sh0, 26'h0, 1'b0, 1'b0, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_UPDATE, 48'sh10000, 26'h0, 1'b1, 1'b1, 1'b0, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b1, 26'sh0, 32'd0},
        '{tlbp_pkg::ACT_TICK,   48'sh0, 26'h0, 1'b0, 1'b0, 1'b1, 26'sh0, 32'd1}
    };

    tempo_locked_beat_phasor_core dut (.*);

    // 12-unit clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [tlbp_pkg::CNT_W-1:0] bump32(input logic [tlbp_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Apply one accepted word to the phasor state; a tick yields a result word
    task automatic advance_phasor(input logic [1:0] act,
                                  input logic signed [tlbp_pkg::POS_W-1:0] pos,
                                  input logic [tlbp_pkg::BPM_W-1:0] bpm, input logic play,
                                  input logic vld, output bit emits, output tick_word_t got);
        longint p;
        longint frac;
        longint d;
        longint q;
        longint num;
        longint den;
        longint nxt;
        bit active;
        bit started;
        emits = 1'b0;
        got = '0;
        case (act)
            tlbp_pkg::ACT_UPDATE:
            begin
                if (vld)
                begin
                    p = longint'(pos);
                    active = (pos != last_pos_q) && play;
                    started = play && !was_playing_q;
                    frac = 0;
                    if (active)
                    begin
                        // fractional beat; positions below -1.0 beat saturate at -1.0
                        if (p > 0)
                            frac = longint'(pos[tlbp_pkg::POS_FRAC_BITS-1:0])
                                   << (FRAC_BITS - tlbp_pkg::POS_FRAC_BITS);
                        else if (p < -(longint'(1) << tlbp_pkg::POS_FRAC_BITS))
                            frac = -PHASE_ONE;
                        else
                            frac = p * (longint'(1) << (FRAC_BITS - tlbp_pkg::POS_FRAC_BITS));
                        phase_q = frac[FRAC_BITS+1:0];
                        if (started)
                        begin
                            // fresh start: bpm / (60 * rate)
                            den = 60 * longint'(rate_hz) * (longint'(1) << tlbp_pkg::POS_FRAC_BITS);
                            num = longint'(bpm) << FRAC_BITS;
                            q = (den == 0) ? PHASE_ONE : num / den;
                            phase_q = '0;
                            since_start_q = '0;
                        end
                        else
                        begin
                            // wrapped phase change over elapsed samples
                            d = frac - longint'(last_frac_q);
                            if (d < 0)
                                d += PHASE_ONE;
                            if (d <= 0)
                                q = 0;
                            else if (since_update_q == '0)
                                q = PHASE_ONE;
                            else
                                q = d / longint'(since_update_q);
                        end
                        if (q > PHASE_ONE)
                            q = PHASE_ONE;
                        step_q = q[FRAC_BITS:0];
                    end
                    else
                    begin
                        phase_q = PHASE_INACTIVE;
                        step_q = '0;
                    end
                    last_pos_q = pos;
                    last_frac_q = frac[FRAC_BITS+1:0];
                    was_playing_q = play;
                    since_update_q = '0;
                end
            end
            tlbp_pkg::ACT_TICK:
            begin
                emits = 1'b1;
                got.phase = phase_q;
                got.count = since_start_q;
                nxt = longint'(phase_q) + longint'(step_q);
                if (nxt > PHASE_ONE)
                    nxt -= PHASE_ONE;
                phase_q = nxt[FRAC_BITS+1:0];
                since_update_q = bump32(since_update_q);
                since_start_q = bump32(since_start_q);
            end
            tlbp_pkg::ACT_CLEAR:
            begin
                step_q = '0;
                was_playing_q = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Drive one input word after a random gap; valid stays high for the next word
    task automatic send_word(input logic [1:0] act, input logic signed [tlbp_pkg::POS_W-1:0] pos,
                             input logic [tlbp_pkg::BPM_W-1:0] bpm, input logic play,
                             input logic vld, input bit typed, input tick_word_t typed_word);
        int gap;
        bit emits;
        tick_word_t got;
        gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 47) == 0)
            tx_calm = !tx_calm;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        beat_position <= pos;
        tempo_bpm <= bpm;
        transport_playing <= play;
        values_valid <= vld;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_phasor(act, pos, bpm, play, vld, emits, got);
        if (emits)
            pending_ticks.push_back(typed ? typed_word : got);
    endtask

    // Mostly ticks and a host walking forward in beats, plus clears, stray codes and bad values
    task automatic send_random_word();
        logic [1:0] act;
        logic signed [tlbp_pkg::POS_W-1:0] pos;
        logic [tlbp_pkg::BPM_W-1:0] bpm;
        logic play;
        logic vld;
        int pick;
        pick = $urandom_range(0, 99);
        pos = tlbp_pkg::POS_W'({$urandom, $urandom});
        bpm = tlbp_pkg::BPM_W'($urandom);
        play = 1'($urandom);
        vld = 1'($urandom);
        act = tlbp_pkg::ACT_TICK;
        if (pick < 55)
            act = tlbp_pkg::ACT_TICK;
        else if (pick < 86)
        begin
            act = tlbp_pkg::ACT_UPDATE;
            vld = ($urandom_range(0, 24) != 0);
            play = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 9))
                0: ;
                1: pos = tlbp_pkg::POS_W'(longint'($urandom_range(0, 'h40000)) - 'sh20000);
                default: pos = host_pos + tlbp_pkg::POS_W'($urandom_range(0, 'h6000));
            endcase
            if ($urandom_range(0, 3) != 0)
                bpm = session_bpm;
            if (vld)
                host_pos = pos;
        end
        else if (pick < 92)
            act = tlbp_pkg::ACT_CLEAR;
        else if (pick < 96)
            act = ACT_SPARE;
        else
        begin
            act = tlbp_pkg::ACT_UPDATE;
            vld = 1'b0;
        end
        send_word(act, pos, bpm, play, vld, 1'b0, '0);
    endtask

    // Write sample_rate once the block has gone quiet
    task automatic set_sample_rate(input logic [tlbp_pkg::SR_W-1:0] hz);
        in_valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sample_rate <= hz;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        rate_hz = hz;
    endtask

    // Result side: check each taken word, then stall for a random count
    always @(posedge clk)
    begin
        tick_word_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_ticks.size() == 0)
                begin
                    $error("result word with none expected: beat_phase %0d samples_since_start %0d",
                           beat_phase, samples_since_start);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_ticks.pop_front();
                    if (beat_phase !== want.phase)
                    begin
                        $error("beat_phase expected %0d actual %0d", want.phase, beat_phase);
                        mismatch_count++;
                    end
                    if (samples_since_start !== want.count)
                    begin
                        $error("samples_since_start expected %0d actual %0d",
                               want.count, samples_since_start);
                        mismatch_count++;
                    end
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
                if ($urandom_range(0, 47) == 0)
                    rx_calm = !rx_calm;
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    initial
    begin
        tick_word_t typed_word;
        int ph;
        int n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script at the reset rate
        foreach (script[r])
        begin
            typed_word.phase = script[r].phase;
            typed_word.count = script[r].count;
            send_word(script[r].act, script[r].pos, script[r].bpm, script[r].play,
                      script[r].vld, script[r].typed, typed_word);
        end

        // random traffic, one sample rate per phase
        for (ph = 0; ph < 7; ph++)
        begin
            set_sample_rate(rate_plan[ph]);
            session_bpm = tlbp_pkg::BPM_W'(($urandom_range(40, 240) << tlbp_pkg::POS_FRAC_BITS)
                                           | $urandom_range(0, 'hFFFF));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_word();
        end

        in_valid <= 1'b0;
        n = 0;
        while (pending_ticks.size() != 0 && n < FINAL_WAIT_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (pending_ticks.size() != 0)
        begin
            $error("%0d result words never arrived", pending_ticks.size());
            mismatch_count++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tempo_locked_beat_phasor_core_test: clean");
        else
            $display("tempo_locked_beat_phasor_core_test: errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #(RUN_LIMIT);
        $display("tempo_locked_beat_phasor_core_test: errors");
        $finish;
    end

endmodule
